@@ rtl/payload_parameter_parser_unit_assert.svh @@
// ============================================================================
// payload parameter parser assertion macros
// shared assertion forms for the parser checker, clocked on clk, off in reset
// ============================================================================
`ifndef PAYLOAD_PARAMETER_PARSER_UNIT_ASSERT_SVH
`define PAYLOAD_PARAMETER_PARSER_UNIT_ASSERT_SVH

// condition that holds on every clock edge out of reset
`define PPP_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("parser check failed");

// consequent that holds in the same cycle as the antecedent
`define PPP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("parser check failed");

// consequent that holds in the cycle after the antecedent
`define PPP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("parser check failed");

`endif

@@ rtl/ppp_pkg.sv @@
// ============================================================================
// ppp_pkg
// types and constants shared by the payload parameter parser modules
// ============================================================================
package ppp_pkg;

    // parser phase codes
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_VALUE  = 2'd1;
    localparam logic [1:0] PH_CLEN   = 2'd2;
    localparam logic [1:0] PH_CDATA  = 2'd3;

    // header byte layout
    localparam logic [7:0] TYPE_MASK   = 8'b0011_1111;
    localparam int         CODE_SHIFT  = 6;
    localparam logic [1:0] CODE_CUSTOM = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_payload;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  param_type;
        logic [7:0]  param_size;
        logic [31:0] param_value;
        logic        is_custom;
        logic        truncated;
    } out_item_t;

    // outcome of one parser step
    typedef struct packed {
        logic      emit;
        out_item_t result;
    } ppp_step_t;

endpackage

@@ rtl/ppp_parse.sv @@
// ============================================================================
// ppp_parse
// parser state and the one-byte state update, one step per advance
// ============================================================================
module ppp_parse
    import ppp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  in_item_t  item,
    output ppp_step_t step
);

    logic [1:0]  phase_reg,       phase_next;
    logic [7:0]  bytes_left_reg,  bytes_left_next;
    logic [31:0] value_acc_reg,   value_acc_next;
    logic [1:0]  byte_pos_reg,    byte_pos_next;
    logic [5:0]  held_type_reg,   held_type_next;
    logic [7:0]  held_size_reg,   held_size_next;
    logic        held_custom_reg, held_custom_next;

    always_comb
    begin
        logic [7:0]  b;
        logic        last;
        logic [1:0]  code;
        logic [31:0] shifted;
        logic [31:0] acc_new;
        logic [7:0]  left_dec;
        logic        emit;
        logic        trunc;
        logic [31:0] value;

        b    = item.data_byte;
        last = item.end_of_payload;
        code = b[CODE_SHIFT +: 2];

        unique case (byte_pos_reg)
            2'd0: shifted = {24'd0, b};
            2'd1: shifted = {16'd0, b, 8'd0};
            2'd2: shifted = {8'd0, b, 16'd0};
            2'd3: shifted = {b, 24'd0};
        endcase
        acc_new  = value_acc_reg | shifted;
        left_dec = bytes_left_reg - 8'd1;

        phase_next       = phase_reg;
        bytes_left_next  = bytes_left_reg;
        value_acc_next   = value_acc_reg;
        byte_pos_next    = byte_pos_reg;
        held_type_next   = held_type_reg;
        held_size_next   = held_size_reg;
        held_custom_next = held_custom_reg;
        emit             = 1'b0;
        trunc            = 1'b0;
        value            = 32'd0;

        unique case (phase_reg)
            PH_VALUE:
            begin
                value_acc_next  = acc_new;
                byte_pos_next   = byte_pos_reg + 2'd1;
                bytes_left_next = left_dec;
                value           = acc_new;
                if (left_dec == 8'd0)
                    emit = 1'b1;
                else if (last)
                begin
                    emit  = 1'b1;
                    trunc = 1'b1;
                end
            end
            PH_CLEN:
            begin
                held_size_next = b;
                if (b == 8'd0)
                    emit = 1'b1;
                else if (last)
                begin
                    emit  = 1'b1;
                    trunc = 1'b1;
                end
                else
                begin
                    bytes_left_next = b;
                    phase_next      = PH_CDATA;
                end
            end
            PH_CDATA:
            begin
                bytes_left_next = left_dec;
                if (left_dec == 8'd0)
                    emit = 1'b1;
                else if (last)
                begin
                    emit  = 1'b1;
                    trunc = 1'b1;
                end
            end
            PH_HEADER:
            begin
                held_type_next = b[5:0] & TYPE_MASK[5:0];
                value_acc_next = 32'd0;
                byte_pos_next  = 2'd0;
                if (code == CODE_CUSTOM)
                begin
                    held_custom_next = 1'b1;
                    held_size_next   = 8'd0;
                    if (last)
                    begin
                        emit  = 1'b1;
                        trunc = 1'b1;
                    end
                    else
                        phase_next = PH_CLEN;
                end
                else
                begin
                    held_custom_next = 1'b0;
                    held_size_next   = 8'd1 << code;
                    if (last)
                    begin
                        emit  = 1'b1;
                        trunc = 1'b1;
                    end
                    else
                    begin
                        bytes_left_next = 8'd1 << code;
                        phase_next      = PH_VALUE;
                    end
                end
            end
        endcase

        // a finished or cut-off parameter leaves the parser waiting for a header
        if (emit)
        begin
            phase_next      = PH_HEADER;
            bytes_left_next = 8'd0;
            value_acc_next  = 32'd0;
            byte_pos_next   = 2'd0;
        end

        step.emit               = emit;
        step.result.param_type  = held_type_next;
        step.result.param_size  = held_size_next;
        step.result.param_value = value;
        step.result.is_custom   = held_custom_next;
        step.result.truncated   = trunc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            bytes_left_reg  <= 8'd0;
            value_acc_reg   <= 32'd0;
            byte_pos_reg    <= 2'd0;
            held_type_reg   <= 6'd0;
            held_size_reg   <= 8'd0;
            held_custom_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            bytes_left_reg  <= bytes_left_next;
            value_acc_reg   <= value_acc_next;
            byte_pos_reg    <= byte_pos_next;
            held_type_reg   <= held_type_next;
            held_size_reg   <= held_size_next;
            held_custom_reg <= held_custom_next;
        end
    end

endmodule

@@ rtl/payload_parameter_parser_unit.sv @@
// ============================================================================
// payload_parameter_parser_unit
// splits a byte stream into type-length-value parameters
// ============================================================================
// Takes one payload byte per request on the item channel and returns one
// request on the param channel for each completed parameter, or for a
// parameter cut off by the end-of-payload flag (truncated set). A header
// byte carries the type in its low six bits and a size code in its top
// two: 1, 2 or 4 value bytes gathered little-endian, or a custom length in
// the following byte whose data is skipped and reported with value zero.
// The block sustains one byte per clock cycle while results are accepted:
// each byte is latched in an input register, the parser state is updated
// from it when it is processed, and any result lands in an output register,
// where it is presented until it is accepted.
// While a result waits unaccepted in the output register the byte in the
// input register is held, whether or not it completes a parameter; one
// more byte can still enter an empty input register, after which the input
// side stalls until the result is taken.
// ============================================================================
module payload_parameter_parser_unit
    import ppp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    // byte channel
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    // parameter channel
    output logic      param_valid,
    input  logic      param_ready,
    output out_item_t param
);

    // input register
    logic      item_valid_reg, item_valid_next;
    in_item_t  item_reg;

    // output register
    logic      param_valid_reg, param_valid_next;
    out_item_t param_reg;

    ppp_step_t step;
    logic      step_fire;
    logic      item_accept;

    // the held byte is processed once the output slot is free or draining
    assign step_fire   = item_valid_reg && (!param_valid_reg || param_ready);
    assign item_ready  = !item_valid_reg || step_fire;
    assign item_accept = item_valid && item_ready;

    ppp_parse u_parse
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (step_fire),
        .item    (item_reg),
        .step    (step)
    );

    always_comb
    begin
        if (item_accept)
            item_valid_next = 1'b1;
        else if (step_fire)
            item_valid_next = 1'b0;
        else
            item_valid_next = item_valid_reg;

        // a step only fires when the output slot is free or draining
        if (step_fire)
            param_valid_next = step.emit;
        else
            param_valid_next = param_valid_reg && !param_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg  <= 1'b0;
            param_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg  <= item_valid_next;
            param_valid_reg <= param_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (item_accept)
            item_reg <= item;
        if (step_fire && step.emit)
            param_reg <= step.result;
    end

    assign param_valid = param_valid_reg;
    assign param       = param_reg;

endmodule

@@ rtl/ppp_checker.sv @@
// ============================================================================
// ppp_checker
// port-level checks on the payload parameter parser, bound to the top level
// ============================================================================
`include "payload_parameter_parser_unit_assert.svh"

module ppp_checker
    import ppp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      param_valid,
    input logic      param_ready,
    input out_item_t param
);

    logic fixed_size_ok;
    logic upper_bytes_zero;

    assign fixed_size_ok = (param.param_size == 8'd1) || (param.param_size == 8'd2)
                        || (param.param_size == 8'd4);
    assign upper_bytes_zero =
        ((param.param_size != 8'd1) || (param.param_value[31:8] == 24'd0))
        && ((param.param_size != 8'd2) || (param.param_value[31:16] == 16'd0));

    // stalled result holds
    `PPP_ASSERT_NEXT(a_param_hold, param_valid && !param_ready,
        param_valid && $stable(param))

    // fixed-size parameter reports 1, 2 or 4 bytes
    `PPP_ASSERT_IMPL(a_fixed_size, param_valid && !param.is_custom, fixed_size_ok)

    // value bytes past the size stay zero
    `PPP_ASSERT_IMPL(a_value_width, param_valid && !param.is_custom, upper_bytes_zero)

    // custom data never shows up as a value
    `PPP_ASSERT_IMPL(a_custom_zero, param_valid && param.is_custom,
        param.param_value == 32'd0)

endmodule

bind payload_parameter_parser_unit ppp_checker u_ppp_checker (.*);
